// ===== hw/rtl/sit_pkg.sv =====
// Shared types, widths and helper functions for the segment intersection test.
// Used by every stage module and the top level; depends on nothing else.
`timescale 1ns / 1ps

package sit_pkg;

  // Coordinate width and the widths that grow from it through the datapath.
  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;

  // Number of orientation products formed for one pair of segments.
  localparam int NUM_ORIENT = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;

  // Stage 1 result: edge vectors of both segments, the offset of each tested
  // endpoint from the base of the other segment, and the bounding box hits.
  typedef struct packed {
    diff_t                   a_dx;
    diff_t                   a_dy;
    diff_t                   b_dx;
    diff_t                   b_dy;
    diff_t [NUM_ORIENT-1:0]  r_dx;
    diff_t [NUM_ORIENT-1:0]  r_dy;
    logic  [NUM_ORIENT-1:0]  box;
  } diff_bundle_t;

  // Stage 2 result: the two partial products of each cross product.
  typedef struct packed {
    prod_t [NUM_ORIENT-1:0]  lhs;
    prod_t [NUM_ORIENT-1:0]  rhs;
    logic  [NUM_ORIENT-1:0]  box;
  } prod_bundle_t;

  // Stage 3 result: sign class of each cross product.
  typedef struct packed {
    logic [NUM_ORIENT-1:0] pos;
    logic [NUM_ORIENT-1:0] neg;
    logic [NUM_ORIENT-1:0] box;
  } sign_bundle_t;

  // Difference of two coordinates, exact in one extra bit.
  function automatic diff_t sub_coord(coord_t a, coord_t b);
    diff_t ax;
    diff_t bx;
    ax = diff_t'({a[COORD_BITS-1], a});
    bx = diff_t'({b[COORD_BITS-1], b});
    return ax - bx;
  endfunction

  // True when point r lies in the closed bounding box of segment p..q.
  function automatic logic in_box(coord_t px, coord_t py, coord_t qx, coord_t qy,
                                  coord_t rx, coord_t ry);
    coord_t lo_x;
    coord_t hi_x;
    coord_t lo_y;
    coord_t hi_y;
    lo_x = (px < qx) ? px : qx;
    hi_x = (px > qx) ? px : qx;
    lo_y = (py < qy) ? py : qy;
    hi_y = (py > qy) ? py : qy;
    return (lo_x <= rx) && (rx <= hi_x) && (lo_y <= ry) && (ry <= hi_y);
  endfunction

endpackage

// ===== hw/rtl/sit_diff_stage.sv =====
// First pipeline stage: coordinate differences and bounding box tests.
// Depends on sit_pkg.
`timescale 1ns / 1ps

module sit_diff_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  sit_pkg::coord_t       a0_x,
  input  sit_pkg::coord_t       a0_y,
  input  sit_pkg::coord_t       a1_x,
  input  sit_pkg::coord_t       a1_y,
  input  sit_pkg::coord_t       b0_x,
  input  sit_pkg::coord_t       b0_y,
  input  sit_pkg::coord_t       b1_x,
  input  sit_pkg::coord_t       b1_y,
  output logic                  out_vld,
  output sit_pkg::diff_bundle_t out_data
);
  import sit_pkg::*;

  diff_bundle_t data_next;

  // Orientations 0 and 1 test segment A's endpoints against B, 2 and 3 the reverse.
  always_comb begin
    data_next.a_dx    = sub_coord(a1_x, a0_x);
    data_next.a_dy    = sub_coord(a1_y, a0_y);
    data_next.b_dx    = sub_coord(b1_x, b0_x);
    data_next.b_dy    = sub_coord(b1_y, b0_y);
    data_next.r_dx[0] = sub_coord(a0_x, b0_x);
    data_next.r_dy[0] = sub_coord(a0_y, b0_y);
    data_next.r_dx[1] = sub_coord(a1_x, b0_x);
    data_next.r_dy[1] = sub_coord(a1_y, b0_y);
    data_next.r_dx[2] = sub_coord(b0_x, a0_x);
    data_next.r_dy[2] = sub_coord(b0_y, a0_y);
    data_next.r_dx[3] = sub_coord(b1_x, a0_x);
    data_next.r_dy[3] = sub_coord(b1_y, a0_y);
    data_next.box[0]  = in_box(b0_x, b0_y, b1_x, b1_y, a0_x, a0_y);
    data_next.box[1]  = in_box(b0_x, b0_y, b1_x, b1_y, a1_x, a1_y);
    data_next.box[2]  = in_box(a0_x, a0_y, a1_x, a1_y, b0_x, b0_y);
    data_next.box[3]  = in_box(a0_x, a0_y, a1_x, a1_y, b1_x, b1_y);
  end

  // Valid bit is control state; the payload register needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hw/rtl/sit_prod_stage.sv =====
// Second pipeline stage: the eight partial products of the cross products.
// Depends on sit_pkg.
`timescale 1ns / 1ps

module sit_prod_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  sit_pkg::diff_bundle_t in_data,
  output logic                  out_vld,
  output sit_pkg::prod_bundle_t out_data
);
  import sit_pkg::*;

  prod_bundle_t data_next;

  // Each orientation multiplies the tested offset by the edge of the other segment.
  always_comb begin
    data_next.box = in_data.box;
    for (int k = 0; k < NUM_ORIENT; k++) begin
      if (k < 2) begin
        data_next.lhs[k] = $signed(in_data.r_dx[k]) * $signed(in_data.b_dy);
        data_next.rhs[k] = $signed(in_data.r_dy[k]) * $signed(in_data.b_dx);
      end else begin
        data_next.lhs[k] = $signed(in_data.r_dx[k]) * $signed(in_data.a_dy);
        data_next.rhs[k] = $signed(in_data.r_dy[k]) * $signed(in_data.a_dx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hw/rtl/sit_sign_stage.sv =====
// Third pipeline stage: cross product subtraction and sign classification.
// Depends on sit_pkg.
`timescale 1ns / 1ps

module sit_sign_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  sit_pkg::prod_bundle_t in_data,
  output logic                  out_vld,
  output sit_pkg::sign_bundle_t out_data
);
  import sit_pkg::*;

  sign_bundle_t data_next;
  cross_t       cross_sum [NUM_ORIENT];

  // The difference is exact one bit wider than the products; zero is neither sign.
  always_comb begin
    data_next.box = in_data.box;
    for (int k = 0; k < NUM_ORIENT; k++) begin
      cross_sum[k] = cross_t'({in_data.lhs[k][PROD_W-1], in_data.lhs[k]})
                   - cross_t'({in_data.rhs[k][PROD_W-1], in_data.rhs[k]});
      data_next.neg[k] = cross_sum[k][CROSS_W-1];
      data_next.pos[k] = !cross_sum[k][CROSS_W-1] && (cross_sum[k] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hw/rtl/segment_intersection_test_core.sv =====
// Top level of the segment intersection test: three pipeline stages and the output register.
// Depends on sit_pkg, sit_diff_stage, sit_prod_stage and sit_sign_stage.
`timescale 1ns / 1ps

// Takes one pair of segments per cycle while not stalled and returns one bit per pair,
// 1 when the segments cross or touch, in the order the pairs arrived. A transfer on the
// input passes through the stages in order: stage 1 forms coordinate differences and
// bounding box tests, stage 2 the eight 17 by 17 bit products, stage 3 the four cross
// products and their signs, and the output register the final decision. The throughput
// is one pair per clock while the output is not stalled. A stall on the output holds
// every stage in place, and in_stall follows it whenever the output register is full.
// Reset clears the valid bits only.
module segment_intersection_test_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  sit_pkg::coord_t seg_a_start_x,
  input  sit_pkg::coord_t seg_a_start_y,
  input  sit_pkg::coord_t seg_a_end_x,
  input  sit_pkg::coord_t seg_a_end_y,
  input  sit_pkg::coord_t seg_b_start_x,
  input  sit_pkg::coord_t seg_b_start_y,
  input  sit_pkg::coord_t seg_b_end_x,
  input  sit_pkg::coord_t seg_b_end_y,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            segments_meet
);
  import sit_pkg::*;

  logic         en;
  logic         s1_vld;
  logic         s2_vld;
  logic         s3_vld;
  diff_bundle_t s1_data;
  prod_bundle_t s2_data;
  sign_bundle_t s3_data;
  logic [NUM_ORIENT-1:0] zero;
  logic         cross_a;
  logic         cross_b;
  logic         meet_next;

  // The whole pipeline advances unless a full output register is stalled.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  sit_diff_stage u_diff (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (in_valid),
    .a0_x     (seg_a_start_x),
    .a0_y     (seg_a_start_y),
    .a1_x     (seg_a_end_x),
    .a1_y     (seg_a_end_y),
    .b0_x     (seg_b_start_x),
    .b0_y     (seg_b_start_y),
    .b1_x     (seg_b_end_x),
    .b1_y     (seg_b_end_y),
    .out_vld  (s1_vld),
    .out_data (s1_data)
  );

  sit_prod_stage u_prod (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s1_vld),
    .in_data  (s1_data),
    .out_vld  (s2_vld),
    .out_data (s2_data)
  );

  sit_sign_stage u_sign (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s2_vld),
    .in_data  (s2_data),
    .out_vld  (s3_vld),
    .out_data (s3_data)
  );

  // Strict straddle in both directions, or a collinear endpoint inside the other box.
  always_comb begin
    zero      = ~s3_data.pos & ~s3_data.neg;
    cross_a   = (s3_data.pos[0] && s3_data.neg[1]) || (s3_data.neg[0] && s3_data.pos[1]);
    cross_b   = (s3_data.pos[2] && s3_data.neg[3]) || (s3_data.neg[2] && s3_data.pos[3]);
    meet_next = (cross_a && cross_b) || (|(zero & s3_data.box));
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      segments_meet <= meet_next;
    end
  end

  // The input is held off only while a result waits at the output.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // An accepted transfer occupies the first stage on the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_vld)
    else $error("accepted pair did not enter the pipeline");

  // A valid item in the last stage moves to the output when the pipeline advances.
  a_last_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (en && s3_vld) |=> out_valid)
    else $error("result lost between last stage and output");

  // While the output is stalled, no stage gains or drops an item.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(s1_vld) && $stable(s2_vld) && $stable(s3_vld)))
    else $error("pipeline valid bits changed during a stall");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for segment_intersection_test_core: drives pairs of segments,
// predicts the touch/cross decision in signed 64-bit arithmetic and checks every result.
// Depends on sit_pkg and segment_intersection_test_core.
`timescale 1ns / 1ps

module tb_top;
  import sit_pkg::*;

  // One pair of segments as it is presented on the input ports.
  typedef struct packed {
    coord_t a_sx;
    coord_t a_sy;
    coord_t a_ex;
    coord_t a_ey;
    coord_t b_sx;
    coord_t b_sy;
    coord_t b_ex;
    coord_t b_ey;
  } seg_pair_t;

  // Holds the expected decision for each accepted pair and compares results in order.
  class meet_scoreboard;
    bit meet_expected_q[$];
    int pair_index_q[$];
    int pairs_seen;
    int errors;

    // Twice the signed area of the triangle p, q, r; its sign tells on which side of p..q r lies.
    function longint turn(longint px, longint py, longint qx, longint qy,
                          longint rx, longint ry);
      return (rx - px) * (qy - py) - (ry - py) * (qx - px);
    endfunction

    // Point r lies in the closed bounding box of p..q.
    function bit bbox_holds(longint px, longint py, longint qx, longint qy,
                            longint rx, longint ry);
      longint lo_x;
      longint hi_x;
      longint lo_y;
      longint hi_y;
      lo_x = (px < qx) ? px : qx;
      hi_x = (px > qx) ? px : qx;
      lo_y = (py < qy) ? py : qy;
      hi_y = (py > qy) ? py : qy;
      return (lo_x <= rx) && (rx <= hi_x) && (lo_y <= ry) && (ry <= hi_y);
    endfunction

    function bit straddle(longint u, longint v);
      return (u > 0 && v < 0) || (u < 0 && v > 0);
    endfunction

    // Expected decision: strict crossing, or a collinear endpoint inside the other box.
    function bit segments_touch(seg_pair_t p);
      longint ax0;
      longint ay0;
      longint ax1;
      longint ay1;
      longint bx0;
      longint by0;
      longint bx1;
      longint by1;
      longint d1;
      longint d2;
      longint d3;
      longint d4;
      ax0 = longint'($signed(p.a_sx));
      ay0 = longint'($signed(p.a_sy));
      ax1 = longint'($signed(p.a_ex));
      ay1 = longint'($signed(p.a_ey));
      bx0 = longint'($signed(p.b_sx));
      by0 = longint'($signed(p.b_sy));
      bx1 = longint'($signed(p.b_ex));
      by1 = longint'($signed(p.b_ey));
      d1 = turn(bx0, by0, bx1, by1, ax0, ay0);
      d2 = turn(bx0, by0, bx1, by1, ax1, ay1);
      d3 = turn(ax0, ay0, ax1, ay1, bx0, by0);
      d4 = turn(ax0, ay0, ax1, ay1, bx1, by1);
      return (straddle(d1, d2) && straddle(d3, d4)) ||
             (d1 == 0 && bbox_holds(bx0, by0, bx1, by1, ax0, ay0)) ||
             (d2 == 0 && bbox_holds(bx0, by0, bx1, by1, ax1, ay1)) ||
             (d3 == 0 && bbox_holds(ax0, ay0, ax1, ay1, bx0, by0)) ||
             (d4 == 0 && bbox_holds(ax0, ay0, ax1, ay1, bx1, by1));
    endfunction

    // Called for every input transfer.
    function void note_pair(seg_pair_t p);
      meet_expected_q.push_back(segments_touch(p));
      pair_index_q.push_back(pairs_seen);
      pairs_seen++;
    endfunction

    // Called for every output transfer.
    function void check_meet(bit got);
      bit want;
      int idx;
      if (meet_expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: segments_meet=%0b with no pair outstanding", got);
        end
        return;
      end
      want = meet_expected_q.pop_front();
      idx = pair_index_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("pair %0d: segments_meet expected %0b actual %0b", idx, want, got);
        end
      end
    endfunction

    function int outstanding();
      return meet_expected_q.size();
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PAIRS_PER_PHASE = 190;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t seg_a_start_x = '0;
  coord_t seg_a_start_y = '0;
  coord_t seg_a_end_x = '0;
  coord_t seg_a_end_y = '0;
  coord_t seg_b_start_x = '0;
  coord_t seg_b_start_y = '0;
  coord_t seg_b_end_x = '0;
  coord_t seg_b_end_y = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   segments_meet;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  meet_scoreboard meet_sb = new();

  segment_intersection_test_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .seg_a_start_x (seg_a_start_x),
    .seg_a_start_y (seg_a_start_y),
    .seg_a_end_x   (seg_a_end_x),
    .seg_a_end_y   (seg_a_end_y),
    .seg_b_start_x (seg_b_start_x),
    .seg_b_start_y (seg_b_start_y),
    .seg_b_end_x   (seg_b_end_x),
    .seg_b_end_y   (seg_b_end_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .segments_meet (segments_meet)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure, changed only at the falling edge.
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Output checking and the watchdog on lack of progress.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      meet_sb.check_meet(segments_meet);
    end
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (!in_valid && meet_sb.outstanding() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic seg_pair_t mk_pair(int ax0, int ay0, int ax1, int ay1,
                                        int bx0, int by0, int bx1, int by1);
    seg_pair_t p;
    p.a_sx = coord_t'(ax0);
    p.a_sy = coord_t'(ay0);
    p.a_ex = coord_t'(ax1);
    p.a_ey = coord_t'(ay1);
    p.b_sx = coord_t'(bx0);
    p.b_sy = coord_t'(by0);
    p.b_ex = coord_t'(bx1);
    p.b_ey = coord_t'(by1);
    return p;
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(16)) - 8;
  endfunction

  function automatic int extreme_coord();
    int picks[5];
    picks = '{-32768, -1, 0, 1, 32767};
    return picks[$urandom_range(4)];
  endfunction

  // Random pair, weighted toward collinear and touching geometry where the
  // decision is hardest, with full-range noise and extreme values mixed in.
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int sel;
    int x0;
    int y0;
    int dx;
    int dy;
    int t;
    int s;
    int s2;
    sel = $urandom_range(99);
    x0 = int'($urandom_range(2000)) - 1000;
    y0 = int'($urandom_range(2000)) - 1000;
    if (sel < 30) begin
      // Both segments on one line, or B starting on the line of A.
      dx = int'($urandom_range(40)) - 20;
      dy = int'($urandom_range(40)) - 20;
      t = $urandom_range(10);
      s = int'($urandom_range(14)) - 2;
      s2 = int'($urandom_range(14)) - 2;
      p = mk_pair(x0, y0, x0 + t * dx, y0 + t * dy, x0 + s * dx, y0 + s * dy,
                  x0 + s2 * dx, y0 + s2 * dy);
      if ($urandom_range(1) == 1) begin
        p.b_ex = coord_t'(x0 + s * dx + small_coord());
        p.b_ey = coord_t'(y0 + s * dy + small_coord());
      end
    end else if (sel < 55) begin
      p = mk_pair(small_coord(), small_coord(), small_coord(), small_coord(),
                  small_coord(), small_coord(), small_coord(), small_coord());
    end else if (sel < 85) begin
      p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
    end else if (sel < 93) begin
      p = mk_pair(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                  extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
    end else begin
      // A zero-length segment acting as a single point.
      p = mk_pair(small_coord(), small_coord(), small_coord(), small_coord(),
                  small_coord(), small_coord(), 0, 0);
      p.b_ex = p.b_sx;
      p.b_ey = p.b_sy;
      if ($urandom_range(1) == 1) begin
        p = {p.b_sx, p.b_sy, p.b_ex, p.b_ey, p.a_sx, p.a_sy, p.a_ex, p.a_ey};
      end
    end
    return p;
  endfunction

  // Presents one pair and holds it until the transfer. Entered and left at a
  // falling edge; valid stays high when the next pair follows with no gap.
  task automatic send_pair(input seg_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    seg_a_start_x = p.a_sx;
    seg_a_start_y = p.a_sy;
    seg_a_end_x = p.a_ex;
    seg_a_end_y = p.a_ey;
    seg_b_start_x = p.b_sx;
    seg_b_start_y = p.b_sy;
    seg_b_end_x = p.b_ex;
    seg_b_end_y = p.b_ey;
    do begin
      @(posedge clk);
    end while (in_stall);
    meet_sb.note_pair(p);
    @(negedge clk);
  endtask

  task automatic send_random(input int count, input int idle_pct, input int hold_pct);
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    repeat (count) send_pair(random_pair());
  endtask

  // Stimulus: reset, directed geometry, then random phases with varied idling.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Crossing, parallel, collinear overlap and gap, T junction, shared endpoint.
    send_pair(mk_pair(-10, -10, 10, 10, -10, 10, 10, -10));
    send_pair(mk_pair(0, 0, 10, 0, 0, 1, 10, 1));
    send_pair(mk_pair(0, 0, 10, 0, 5, 0, 15, 0));
    send_pair(mk_pair(0, 0, 10, 0, 11, 0, 20, 0));
    send_pair(mk_pair(0, 0, 10, 0, 5, 0, 5, 7));
    send_pair(mk_pair(0, 0, 10, 10, 10, 10, 20, 0));
    send_pair(mk_pair(0, 0, 0, 10, 0, 5, 0, 20));
    // Zero-length segments: on, off, coincident points, distinct points.
    send_pair(mk_pair(3, 3, 3, 3, 0, 0, 6, 6));
    send_pair(mk_pair(3, 4, 3, 4, 0, 0, 6, 6));
    send_pair(mk_pair(2, 2, 2, 2, 2, 2, 2, 2));
    send_pair(mk_pair(2, 2, 2, 2, 2, 3, 2, 3));
    // A point just off the line of A must not count as collinear.
    send_pair(mk_pair(0, 0, 100, 1, 50, 0, 50, -5));
    // Full-range coordinates and the largest products.
    send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(mk_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(mk_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(mk_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
    send_pair(mk_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    send_pair(mk_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_pair(mk_pair(-1, -1, 0, 0, 1, 1, 32767, 32767));
    send_pair(mk_pair(-32768, -32768, 32767, 32766, 32767, 32767, -32768, -32767));

    send_random(PAIRS_PER_PHASE, 0, 0);
    send_random(PAIRS_PER_PHASE, 53, 0);
    send_random(PAIRS_PER_PHASE, 0, 53);
    send_random(PAIRS_PER_PHASE, 36, 36);
    in_valid = 1'b0;

    // Let the pipeline drain, then watch a little longer for stray results.
    while (meet_sb.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (meet_sb.errors == 0 && meet_sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
